// ===== hdl/e2q_pkg.sv =====
// ----------------------------------------------------------------------------
// e2q_pkg: shared types and constants of the equirectangular projector
// Holds the CORDIC cell bundle, the side-band bundle that travels alongside
// the arithmetic, the fixed pose of the camera and the arctangent steps.
// ----------------------------------------------------------------------------
package e2q_pkg;

	// Width of the CORDIC x and y words and of the binary angle.
	localparam int CW = 46;
	localparam int AW = 34;

	// Most CORDIC steps that the angle table supports.
	localparam int MAX_STEPS = 24;

	// Quotient bits of the back-projection divider.
	localparam int DIV_N = 40;

	// Reciprocal of the CORDIC gain in Q.16.
	localparam logic [15:0] INV_GAIN = 16'd39797;

	// A quarter turn in binary angle units.
	localparam logic signed [AW-1:0] QUARTER_TURN = 34'sd1073741824;

	// Configuration register indices.
	typedef enum logic [2:0] {
		REG_FOCAL_X     = 3'd0,
		REG_FOCAL_Y     = 3'd1,
		REG_CENTER_X    = 3'd2,
		REG_CENTER_Y    = 3'd3,
		REG_EQUI_WIDTH  = 3'd4,
		REG_EQUI_HEIGHT = 3'd5
	} reg_idx_t;

	// One vector and its accumulated angle inside a CORDIC chain.
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [AW-1:0] z;
	} cord_t;

	// Fields that ride alongside the arithmetic unchanged.
	typedef struct packed {
		logic        ok;
		logic        sx;
		logic        sy;
		logic [15:0] depth;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} side_t;

	typedef logic signed [16:0] coef_t;
	typedef logic signed [18:0] trans_t;

	// Rotation of the camera frame in Q.16.
	localparam coef_t ROT [3][3] = '{
		'{17'sd884,   -17'sd65504, -17'sd1860},
		'{17'sd65526,  17'sd903,   -17'sd667},
		'{17'sd692,   -17'sd1851,   17'sd65506}
	};

	// Translation in Q.8 of 1/5000 m.
	localparam trans_t TRANS [3] = '{19'sd110418, 19'sd182047, 19'sd27239};

	// Arctangent of 2^-i in binary angle units, rounded.
	function automatic logic signed [AW-1:0] atan_step(input int i);
		logic signed [AW-1:0] r;
		case (i)
			0:  r = 34'sd536870912;
			1:  r = 34'sd316933406;
			2:  r = 34'sd167458907;
			3:  r = 34'sd85004756;
			4:  r = 34'sd42667331;
			5:  r = 34'sd21354465;
			6:  r = 34'sd10679838;
			7:  r = 34'sd5340245;
			8:  r = 34'sd2670163;
			9:  r = 34'sd1335087;
			10: r = 34'sd667544;
			11: r = 34'sd333772;
			12: r = 34'sd166886;
			13: r = 34'sd83443;
			14: r = 34'sd41722;
			15: r = 34'sd20861;
			16: r = 34'sd10430;
			17: r = 34'sd5215;
			18: r = 34'sd2608;
			19: r = 34'sd1304;
			20: r = 34'sd652;
			21: r = 34'sd326;
			22: r = 34'sd163;
			23: r = 34'sd81;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/rgbd_pixel_to_equirect_top.sv =====
// ----------------------------------------------------------------------------
// rgbd_pixel_to_equirect_top: RGB-D pixel to equirectangular projector
// Back-projects a perspective pixel, moves it by the fixed camera pose and
// maps it to an equirectangular column, row and range.
// ----------------------------------------------------------------------------
// Usage
//   Pixels enter on the s_axis stream and one result per pixel leaves on the
//   m_axis stream, in order. Each transaction moves one pixel or one result.
//   The cfg channel writes the focal, principal point and output size
//   registers; it is always ready and is only to be used while idle.
//   Throughput is one pixel per clock while the receiver is ready. Each
//   pixel passes through the two 40-cell divider chains that form the
//   back-projected x and y, the two CORDIC cell chains for azimuth and
//   elevation (16 cells each by default), and twelve stages of multiplies,
//   sums and clamping.
//   When the receiver stalls, the whole pipeline holds; one more pixel is
//   still taken into a skid register, then s_axis_tready falls until the
//   stall ends. Reset empties the pipeline and the skid register and loads
//   the configuration registers with their default values.
// ----------------------------------------------------------------------------
module rgbd_pixel_to_equirect_top #(
	parameter int PERS_WIDTH   = 1280,
	parameter int PERS_HEIGHT  = 720,
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// pix_col[10:0], pix_row[20:11], depth_in[36:21], red_in[44:37],
	// green_in[52:45], blue_in[60:53], zero[63:61]
	input  logic [63:0] s_axis_tdata,
	// sample_inside[0]
	input  logic [0:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// equi_col[11:0], equi_row[23:12], red_out[31:24], green_out[39:32],
	// blue_out[47:40], range_out[63:48]
	output logic [63:0] m_axis_tdata,
	// write_enable[0]
	output logic [0:0]  m_axis_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int CW    = e2q_pkg::CW;
	localparam int AW    = e2q_pkg::AW;
	localparam int DIV_N = e2q_pkg::DIV_N;
	localparam int NSTEP = (CORDIC_STEPS > e2q_pkg::MAX_STEPS) ?
		e2q_pkg::MAX_STEPS : CORDIC_STEPS;

	// Stage numbers along the pipeline.
	localparam int K_P  = 4 + DIV_N;
	localparam int K_M  = K_P + 1;
	localparam int K_S  = K_M + 1;
	localparam int K_Q  = K_S + 1;
	localparam int K_C1 = K_Q + 1;
	localparam int K_K  = K_C1 + NSTEP + 1;
	localparam int K_C2 = K_K + 1;
	localparam int K_F  = K_C2 + NSTEP + 1;

	// Configuration registers.
	logic [15:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
	logic [12:0] equi_width_q, equi_height_q;
	logic [15:0] fx_w, fy_w;

	// Flow control and skid register.
	logic        ce;
	logic        in_hs;
	logic        skid_v_q;
	logic [63:0] skid_data_q;
	logic        skid_user_q;
	logic [63:0] src_data;
	logic        src_user;
	logic        src_v;
	logic [K_F:1] vld_s;
	e2q_pkg::side_t side_s [1:K_F];

	// Early stages.
	logic [10:0]        col_s1;
	logic [9:0]         row_s1;
	logic signed [17:0] dxw, dyw;
	logic [16:0]        ax_s2, ay_s2;
	logic [32:0]        prx_w, pry_w;
	logic [31:0]        prx_s3, pry_s3;

	// Divider chains.
	logic [15:0]      remx_w [0:DIV_N];
	logic [15:0]      remy_w [0:DIV_N];
	logic [DIV_N-1:0] nqx_w  [0:DIV_N];
	logic [DIV_N-1:0] nqy_w  [0:DIV_N];

	// Rotation and translation.
	logic signed [DIV_N:0] qx_w, qy_w;
	logic signed [DIV_N:0] pv_s44 [3];
	logic signed [57:0]    mp_s45 [3][3];
	logic signed [59:0]    sum_s46 [3];
	logic signed [59:0]    sh_w [3];
	logic signed [CW-1:0]  q_s47 [3];

	// CORDIC chains and their side lines.
	e2q_pkg::cord_t       pre_w;
	e2q_pkg::cord_t       c1_w [0:NSTEP];
	e2q_pkg::cord_t       c2_w [0:NSTEP];
	e2q_pkg::cord_t       c2_sc2;
	logic signed [CW-1:0] q1_d [K_C1:K_K];
	logic                 sk1_d [K_C1:K_K-1];
	logic                 sk2_d [K_C2:K_F-1];
	logic signed [AW-1:0] th_d [K_K:K_F-1];
	logic [CW-1:0]        mag1_w;
	logic [CW+15:0]       mk_w, mk_sk;
	logic [CW-1:0]        rxz_w;
	logic [CW-1:0]        mag2_w;
	logic signed [AW-1:0] phi_w;
	logic signed [34:0]   tc_w, tr_w;

	// Final products.
	logic [CW+15:0] rg_sf;
	logic [45:0]    cprod_sf, rprod_sf;
	logic           tcn_sf, trn_sf;

	// Output stage.
	logic [13:0] cidx_w;
	logic [14:0] ridx_w;
	logic [12:0] wm1_w, hm1_w;
	logic [11:0] clim_w, rlim_w;
	logic [11:0] col_out_w, row_out_w;
	logic [15:0] rng_w;
	logic        m_tvalid_q;
	logic [63:0] m_tdata_q;
	logic        m_tuser_q;

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q     <= 16'd10075;
			focal_y_q     <= 16'd10062;
			center_x_q    <= 16'd10095;
			center_y_q    <= 16'd5866;
			equi_width_q  <= 13'd1280;
			equi_height_q <= 13'd720;
		end else if (cfg_valid) begin
			case (e2q_pkg::reg_idx_t'(cfg_index))
				e2q_pkg::REG_FOCAL_X:     focal_x_q     <= cfg_data;
				e2q_pkg::REG_FOCAL_Y:     focal_y_q     <= cfg_data;
				e2q_pkg::REG_CENTER_X:    center_x_q    <= cfg_data;
				e2q_pkg::REG_CENTER_Y:    center_y_q    <= cfg_data;
				e2q_pkg::REG_EQUI_WIDTH:  equi_width_q  <= cfg_data[12:0];
				e2q_pkg::REG_EQUI_HEIGHT: equi_height_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// A zero focal length acts as one.
	assign fx_w = (focal_x_q == 16'd0) ? 16'd1 : focal_x_q;
	assign fy_w = (focal_y_q == 16'd0) ? 16'd1 : focal_y_q;

	// ------------------------------------------------------------------
	// Flow control: the pipeline moves whenever the output can move.
	// ------------------------------------------------------------------
	assign ce            = !m_tvalid_q || m_axis_tready;
	assign s_axis_tready = !skid_v_q;
	assign in_hs         = s_axis_tvalid && !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (ce) begin
			skid_v_q <= 1'b0;
		end else if (in_hs) begin
			skid_v_q <= 1'b1;
		end
	end

	// The skid register catches a transaction taken during a stall.
	always_ff @(posedge clk) begin
		if (!ce && in_hs) begin
			skid_data_q <= s_axis_tdata;
			skid_user_q <= s_axis_tuser[0];
		end
	end

	assign src_data = skid_v_q ? skid_data_q : s_axis_tdata;
	assign src_user = skid_v_q ? skid_user_q : s_axis_tuser[0];
	assign src_v    = skid_v_q || in_hs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ce) begin
			vld_s <= {vld_s[K_F-1:1], src_v};
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: unpack and check the pixel position.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (ce) begin
			col_s1            <= src_data[10:0];
			row_s1            <= src_data[20:11];
			side_s[1].ok      <= src_user &&
				({1'b0, src_data[10:0]} < 12'(PERS_WIDTH)) &&
				({2'b0, src_data[20:11]} < 12'(PERS_HEIGHT));
			side_s[1].sx      <= 1'b0;
			side_s[1].sy      <= 1'b0;
			side_s[1].depth   <= src_data[36:21];
			side_s[1].red     <= src_data[44:37];
			side_s[1].green   <= src_data[52:45];
			side_s[1].blue    <= src_data[60:53];
		end
	end

	// Side-band line; stage 2 fills in the signs of the offsets.
	for (genvar k = 2; k <= K_F; k++) begin : g_side
		if (k == 2) begin : g_sign
			always_ff @(posedge clk) begin
				if (ce) begin
					side_s[k] <= {side_s[k-1].ok, dxw[17], dyw[17], side_s[k-1].depth,
						side_s[k-1].red, side_s[k-1].green, side_s[k-1].blue};
				end
			end
		end else begin : g_copy
			always_ff @(posedge clk) begin
				if (ce) begin
					side_s[k] <= side_s[k-1];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: offsets from the principal point, as sign and magnitude.
	// ------------------------------------------------------------------
	assign dxw = $signed({3'b0, col_s1, 4'b0}) - $signed({2'b0, center_x_q});
	assign dyw = $signed({4'b0, row_s1, 4'b0}) - $signed({2'b0, center_y_q});

	always_ff @(posedge clk) begin
		if (ce) begin
			ax_s2 <= dxw[17] ? 17'(-dxw) : dxw[16:0];
			ay_s2 <= dyw[17] ? 17'(-dyw) : dyw[16:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: offset magnitude times depth.
	// ------------------------------------------------------------------
	assign prx_w = {16'b0, ax_s2} * {17'b0, side_s[2].depth};
	assign pry_w = {16'b0, ay_s2} * {17'b0, side_s[2].depth};

	always_ff @(posedge clk) begin
		if (ce) begin
			prx_s3 <= prx_w[31:0];
			pry_s3 <= pry_w[31:0];
		end
	end

	// ------------------------------------------------------------------
	// Divider chains: one quotient bit per cell, dividend scaled by 256.
	// ------------------------------------------------------------------
	assign remx_w[0] = '0;
	assign remy_w[0] = '0;
	assign nqx_w[0]  = {prx_s3, 8'b0};
	assign nqy_w[0]  = {pry_s3, 8'b0};

	for (genvar d = 0; d < DIV_N; d++) begin : g_div
		e2q_div_cell #(
			.NUM_W(DIV_N),
			.DEN_W(16)
		) u_divx (
			.clk    (clk),
			.en     (ce),
			.den    (fx_w),
			.rem_in (remx_w[d]),
			.nq_in  (nqx_w[d]),
			.rem_out(remx_w[d+1]),
			.nq_out (nqx_w[d+1])
		);
		e2q_div_cell #(
			.NUM_W(DIV_N),
			.DEN_W(16)
		) u_divy (
			.clk    (clk),
			.en     (ce),
			.den    (fy_w),
			.rem_in (remy_w[d]),
			.nq_in  (nqy_w[d]),
			.rem_out(remy_w[d+1]),
			.nq_out (nqy_w[d+1])
		);
	end

	// ------------------------------------------------------------------
	// Restore the signs; the quotient truncates towards zero.
	// ------------------------------------------------------------------
	assign qx_w = $signed({1'b0, nqx_w[DIV_N]});
	assign qy_w = $signed({1'b0, nqy_w[DIV_N]});

	always_ff @(posedge clk) begin
		if (ce) begin
			pv_s44[0] <= side_s[K_P-1].sx ? -qx_w : qx_w;
			pv_s44[1] <= side_s[K_P-1].sy ? -qy_w : qy_w;
			pv_s44[2] <= (DIV_N+1)'($signed({1'b0, side_s[K_P-1].depth, 8'b0}));
		end
	end

	// Rotation products.
	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					mp_s45[i][j] <= 58'(pv_s44[j]) * 58'(e2q_pkg::ROT[i][j]);
				end
			end
		end
	end

	// Row sums.
	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				sum_s46[i] <= 60'(mp_s45[i][0]) + 60'(mp_s45[i][1]) + 60'(mp_s45[i][2]);
			end
		end
	end

	// Floor shift back to Q.8 and add the translation.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sh_w[i] = sum_s46[i] >>> 16;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				q_s47[i] <= CW'(sh_w[i]) + CW'(e2q_pkg::TRANS[i]);
			end
		end
	end

	// ------------------------------------------------------------------
	// Azimuth: pre-rotation into the right half plane, then the chain.
	// ------------------------------------------------------------------
	always_comb begin
		pre_w.x = q_s47[2];
		pre_w.y = q_s47[0];
		pre_w.z = '0;
		if (q_s47[2][CW-1]) begin
			if (!q_s47[0][CW-1]) begin
				pre_w.x = q_s47[0];
				pre_w.y = -q_s47[2];
				pre_w.z = e2q_pkg::QUARTER_TURN;
			end else begin
				pre_w.x = -q_s47[0];
				pre_w.y = q_s47[2];
				pre_w.z = -e2q_pkg::QUARTER_TURN;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			c1_w[0]     <= pre_w;
			q1_d[K_C1]  <= q_s47[1];
			sk1_d[K_C1] <= (q_s47[0] == '0) && (q_s47[2] == '0);
		end
	end

	for (genvar c = 0; c < NSTEP; c++) begin : g_c1
		e2q_cordic_cell #(
			.STEP(c)
		) u_cell (
			.clk (clk),
			.en  (ce),
			.cin (c1_w[c]),
			.cout(c1_w[c+1])
		);
	end

	// Lines that wait beside the azimuth chain.
	for (genvar k = K_C1 + 1; k <= K_K; k++) begin : g_q1
		always_ff @(posedge clk) begin
			if (ce) begin
				q1_d[k] <= q1_d[k-1];
			end
		end
	end

	for (genvar k = K_C1 + 1; k <= K_K - 1; k++) begin : g_sk1
		always_ff @(posedge clk) begin
			if (ce) begin
				sk1_d[k] <= sk1_d[k-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Gain correction of the horizontal magnitude.
	// ------------------------------------------------------------------
	assign mag1_w = sk1_d[K_K-1] ? '0 : $unsigned(c1_w[NSTEP].x);
	assign mk_w   = {16'b0, mag1_w} * {CW'(0), e2q_pkg::INV_GAIN};

	always_ff @(posedge clk) begin
		if (ce) begin
			mk_sk     <= mk_w;
			th_d[K_K] <= sk1_d[K_K-1] ? '0 : c1_w[NSTEP].z;
		end
	end

	for (genvar k = K_K + 1; k <= K_F - 1; k++) begin : g_th
		always_ff @(posedge clk) begin
			if (ce) begin
				th_d[k] <= th_d[k-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Elevation: the horizontal magnitude is never negative, so no
	// pre-rotation is needed.
	// ------------------------------------------------------------------
	assign rxz_w = mk_sk[CW+15:16];

	always_ff @(posedge clk) begin
		if (ce) begin
			c2_sc2.x    <= $signed(rxz_w);
			c2_sc2.y    <= q1_d[K_K];
			c2_sc2.z    <= '0;
			sk2_d[K_C2] <= (rxz_w == '0) && (q1_d[K_K] == '0);
		end
	end

	assign c2_w[0] = c2_sc2;

	for (genvar c = 0; c < NSTEP; c++) begin : g_c2
		e2q_cordic_cell #(
			.STEP(c)
		) u_cell (
			.clk (clk),
			.en  (ce),
			.cin (c2_w[c]),
			.cout(c2_w[c+1])
		);
	end

	for (genvar k = K_C2 + 1; k <= K_F - 1; k++) begin : g_sk2
		always_ff @(posedge clk) begin
			if (ce) begin
				sk2_d[k] <= sk2_d[k-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Range scaling and angle to index products.
	// ------------------------------------------------------------------
	assign mag2_w = (sk2_d[K_F-1] || c2_w[NSTEP].x[CW-1]) ? '0 :
		$unsigned(c2_w[NSTEP].x);
	assign phi_w  = sk2_d[K_F-1] ? '0 : c2_w[NSTEP].z;
	assign tc_w   = 35'(th_d[K_F-1]) + 35'sd2147483648;
	assign tr_w   = 35'(phi_w) + 35'sd1073741824;

	always_ff @(posedge clk) begin
		if (ce) begin
			rg_sf    <= {16'b0, mag2_w} * {CW'(0), e2q_pkg::INV_GAIN};
			cprod_sf <= {13'b0, tc_w[32:0]} * {33'b0, equi_width_q};
			rprod_sf <= {13'b0, tr_w[32:0]} * {33'b0, equi_height_q};
			tcn_sf   <= tc_w[34];
			trn_sf   <= tr_w[34];
		end
	end

	// ------------------------------------------------------------------
	// Clamp the indices, saturate the range and register the result.
	// ------------------------------------------------------------------
	assign cidx_w = tcn_sf ? '0 : cprod_sf[45:32];
	assign ridx_w = trn_sf ? '0 : rprod_sf[45:31];
	assign wm1_w  = equi_width_q - 13'd1;
	assign hm1_w  = equi_height_q - 13'd1;
	assign clim_w = (wm1_w > 13'd4095) ? 12'hFFF : wm1_w[11:0];
	assign rlim_w = (hm1_w > 13'd4095) ? 12'hFFF : hm1_w[11:0];

	assign col_out_w = (equi_width_q == '0) ? '0 :
		(cidx_w > {2'b0, clim_w}) ? clim_w : cidx_w[11:0];
	assign row_out_w = (equi_height_q == '0) ? '0 :
		(ridx_w > {3'b0, rlim_w}) ? rlim_w : ridx_w[11:0];
	assign rng_w = (|rg_sf[CW+15:40]) ? 16'hFFFF : rg_sf[39:24];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ce) begin
			m_tvalid_q <= vld_s[K_F];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			m_tuser_q <= side_s[K_F].ok;
			if (side_s[K_F].ok) begin
				m_tdata_q <= {rng_w, side_s[K_F].blue, side_s[K_F].green,
					side_s[K_F].red, row_out_w, col_out_w};
			end else begin
				m_tdata_q <= '0;
			end
		end
	end

	assign m_axis_tvalid   = m_tvalid_q;
	assign m_axis_tdata    = m_tdata_q;
	assign m_axis_tuser[0] = m_tuser_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && ce |=> !skid_v_q)
		else $error("skid register held a transaction across a moving cycle");

	a_unwritten_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && !m_tuser_q |-> m_tdata_q == '0)
		else $error("result without write enable carries non-zero fields");

	a_col_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_tuser_q && equi_width_q != '0 |->
		{1'b0, m_tdata_q[11:0]} <= wm1_w)
		else $error("output column beyond the image width");

	a_row_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_tuser_q && equi_height_q != '0 |->
		{1'b0, m_tdata_q[23:12]} <= hm1_w)
		else $error("output row beyond the image height");

endmodule

// ===== hdl/e2q_div_cell.sv =====
// ----------------------------------------------------------------------------
// e2q_div_cell: one step of a restoring divider chain
// Takes the partial remainder and the dividend/quotient word from the cell
// before it, produces one quotient bit and hands both on, registered.
// ----------------------------------------------------------------------------
module e2q_div_cell #(
	parameter int NUM_W = 40,
	parameter int DEN_W = 16
) (
	input  logic             clk,
	input  logic             en,
	input  logic [DEN_W-1:0] den,
	input  logic [DEN_W-1:0] rem_in,
	input  logic [NUM_W-1:0] nq_in,
	output logic [DEN_W-1:0] rem_out,
	output logic [NUM_W-1:0] nq_out
);

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] nq_q;

	// Bring down the next dividend bit and try a subtraction.
	assign trial = {rem_in, nq_in[NUM_W-1]};
	assign diff  = trial - {1'b0, den};
	assign ge    = trial >= {1'b0, den};

	// The remainder always stays below the divisor, so it fits DEN_W bits.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			nq_q  <= {nq_in[NUM_W-2:0], ge};
		end
	end

	assign rem_out = rem_q;
	assign nq_out  = nq_q;

endmodule

// ===== hdl/e2q_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// e2q_cordic_cell: one vectoring micro-rotation of a CORDIC chain
// Rotates the vector towards the x axis by the fixed angle of its step and
// hands the result, registered, to the next cell.
// ----------------------------------------------------------------------------
module e2q_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic           clk,
	input  logic           en,
	input  e2q_pkg::cord_t cin,
	output e2q_pkg::cord_t cout
);

	logic signed [e2q_pkg::CW-1:0] xi;
	logic signed [e2q_pkg::CW-1:0] yi;
	logic signed [e2q_pkg::AW-1:0] zi;
	logic signed [e2q_pkg::CW-1:0] dx;
	logic signed [e2q_pkg::CW-1:0] dy;
	e2q_pkg::cord_t                nxt;
	e2q_pkg::cord_t                st_q;

	assign xi = cin.x;
	assign yi = cin.y;
	assign zi = cin.z;

	// Floor shifts of the crossed terms.
	assign dx = yi >>> STEP;
	assign dy = xi >>> STEP;

	// The sign of y picks the rotation direction.
	always_comb begin
		if (!yi[e2q_pkg::CW-1]) begin
			nxt.x = xi + dx;
			nxt.y = yi - dy;
			nxt.z = zi + e2q_pkg::atan_step(STEP);
		end else begin
			nxt.x = xi - dx;
			nxt.y = yi + dy;
			nxt.z = zi - e2q_pkg::atan_step(STEP);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= nxt;
		end
	end

	assign cout = st_q;

endmodule

// ===== verif/e2q_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_checker: result predictor and scoreboard for the equirectangular projector
// Watches the pixel, result and register channels. Each accepted pixel is
// projected by an independent integer model. The model's result is queued and
// compared, field by field, with the next result that the block delivers.
// ----------------------------------------------------------------------------
module e2q_checker #(
	parameter int PERS_WIDTH   = 1280,
	parameter int PERS_HEIGHT  = 720,
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,
	input  logic [0:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata,
	input  logic [0:0]  m_axis_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          written
);

	localparam int STEPS = (CORDIC_STEPS > e2q_pkg::MAX_STEPS) ?
		e2q_pkg::MAX_STEPS : CORDIC_STEPS;
	localparam longint HALF = 64'sd2147483648;
	localparam longint QUART = 64'sd1073741824;
	localparam longint GAIN_INV = 64'sd39797;

	typedef struct {
		bit        we;
		bit [11:0] col;
		bit [11:0] row;
		bit [7:0]  red;
		bit [7:0]  green;
		bit [7:0]  blue;
		bit [15:0] rng;
	} equi_pix_t;

	// Arctangent steps and the fixed camera pose.
	localparam longint ATAN [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81};
	localparam longint POSE_ROT [3][3] = '{
		'{884, -65504, -1860}, '{65526, 903, -667}, '{692, -1851, 65506}};
	localparam longint POSE_TRANS [3] = '{110418, 182047, 27239};

	// Local copy of the registers.
	bit [15:0] focal_x, focal_y, center_x, center_y;
	bit [12:0] equi_width, equi_height;

	equi_pix_t projected_q[$];

	// CORDIC vectoring: gain-scaled magnitude and binary angle of (x, y).
	function automatic void vector_angle(input longint x0, input longint y0,
			output longint mag, output longint ang);
		longint x, y, z, dx, dy;
		x = x0;
		y = y0;
		z = 0;
		if (x < 0) begin
			if (y >= 0) begin
				x = y;
				y = -x0;
				z = QUART;
			end else begin
				x = -y;
				y = x0;
				z = -QUART;
			end
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx;
				y -= dy;
				z += ATAN[i];
			end else begin
				x -= dx;
				y += dy;
				z -= ATAN[i];
			end
		end
		mag = x;
		ang = z;
	endfunction

	// Angle to image index, clamped to the image and to 12 bits.
	function automatic bit [11:0] angle_index(input longint ang, input longint offset,
			input int shift, input longint size);
		longint t, idx, lim;
		t = ang + offset;
		if (size == 0)
			return 0;
		idx = (t < 0) ? 0 : ((t * size) >> shift);
		lim = (size - 1 > 4095) ? 4095 : size - 1;
		return (idx > lim) ? lim : idx;
	endfunction

	function automatic equi_pix_t project_pixel(input logic [63:0] d, input bit smp_ok);
		equi_pix_t r;
		longint col, row, depth, fx, fy, mag1, theta, mag2, phi, rxz, rng;
		longint p [3];
		longint q [3];
		r = '{default: 0};
		col = d[10:0];
		row = d[20:11];
		depth = d[36:21];
		if (!smp_ok || col >= PERS_WIDTH || row >= PERS_HEIGHT)
			return r;
		// A zero focal length acts as one.
		fx = (focal_x != 0) ? longint'(focal_x) : 1;
		fy = (focal_y != 0) ? longint'(focal_y) : 1;
		p[0] = ((col * 16 - longint'(center_x)) * depth * 256) / fx;
		p[1] = ((row * 16 - longint'(center_y)) * depth * 256) / fy;
		p[2] = depth * 256;
		for (int i = 0; i < 3; i++)
			q[i] = ((POSE_ROT[i][0] * p[0] + POSE_ROT[i][1] * p[1]
				+ POSE_ROT[i][2] * p[2]) >>> 16) + POSE_TRANS[i];
		mag1 = 0;
		theta = 0;
		mag2 = 0;
		phi = 0;
		if (q[0] != 0 || q[2] != 0)
			vector_angle(q[2], q[0], mag1, theta);
		rxz = (mag1 * GAIN_INV) >>> 16;
		if (rxz != 0 || q[1] != 0)
			vector_angle(rxz, q[1], mag2, phi);
		if (mag2 < 0)
			mag2 = 0;
		rng = (mag2 * GAIN_INV) >>> 24;
		r.we = 1;
		r.col = angle_index(theta, HALF, 32, equi_width);
		r.row = angle_index(phi, QUART, 31, equi_height);
		r.red = d[44:37];
		r.green = d[52:45];
		r.blue = d[60:53];
		r.rng = (rng > 65535) ? 16'hFFFF : rng[15:0];
		return r;
	endfunction

	function automatic void check_field(input string name, input longint exp_v,
			input longint act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endfunction

	// Register writes, pixel predictions and result comparison, all on the edge.
	always @(posedge clk or negedge arst_n) begin
		equi_pix_t e;
		if (!arst_n) begin
			focal_x = 16'd10075;
			focal_y = 16'd10062;
			center_x = 16'd10095;
			center_y = 16'd5866;
			equi_width = 13'd1280;
			equi_height = 13'd720;
			projected_q.delete();
			errors = 0;
			pending = 0;
			written = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (e2q_pkg::reg_idx_t'(cfg_index))
					e2q_pkg::REG_FOCAL_X:     focal_x = cfg_data;
					e2q_pkg::REG_FOCAL_Y:     focal_y = cfg_data;
					e2q_pkg::REG_CENTER_X:    center_x = cfg_data;
					e2q_pkg::REG_CENTER_Y:    center_y = cfg_data;
					e2q_pkg::REG_EQUI_WIDTH:  equi_width = cfg_data[12:0];
					e2q_pkg::REG_EQUI_HEIGHT: equi_height = cfg_data[12:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				projected_q.insert(projected_q.size(),
					project_pixel(s_axis_tdata, s_axis_tuser[0]));
			if (m_axis_tvalid && m_axis_tready) begin
				if (projected_q.size() == 0) begin
					$error("result transaction with no pixel outstanding");
					errors++;
				end else begin
					e = projected_q.pop_front();
					written += e.we;
					check_field("write_enable", e.we, m_axis_tuser[0]);
					check_field("equi_col", e.col, m_axis_tdata[11:0]);
					check_field("equi_row", e.row, m_axis_tdata[23:12]);
					check_field("red_out", e.red, m_axis_tdata[31:24]);
					check_field("green_out", e.green, m_axis_tdata[39:32]);
					check_field("blue_out", e.blue, m_axis_tdata[47:40]);
					check_field("range_out", e.rng, m_axis_tdata[63:48]);
				end
			end
			pending = projected_q.size();
		end
	end

endmodule

// ===== verif/tb_rgbd_pixel_to_equirect_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgbd_pixel_to_equirect_top: stimulus and verdict for the projector
// Writes register settings while idle, sends directed edge-case pixels and
// then random pixels in three phases, two of them under back-pressure, and
// reports a verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_rgbd_pixel_to_equirect_top;

	localparam int RUN_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	int errors, pending, written;
	int tx_idle, rx_idle;
	int pixels_sent, reg_writes;
	longint cycles;
	bit s_fire, cfg_fire;

	always #1 clk = ~clk;

	rgbd_pixel_to_equirect_top dut (.*);

	e2q_checker u_checker (.*);

	// Handshakes as seen at the rising edge, read by the drivers afterwards.
	always @(posedge clk) begin
		s_fire <= s_axis_tvalid && s_axis_tready;
		cfg_fire <= cfg_valid && cfg_ready;
	end

	// Receiver back-pressure.
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= rx_idle);

	// Run limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("Run limit reached with %0d results outstanding", pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_pixel(input int col, input int row, input bit smp_ok,
			input int depth, input int red, input int green, input int blue);
		while ($urandom_range(99) < tx_idle) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {3'b000, 8'(blue), 8'(green), 8'(red), 16'(depth),
			10'(row), 11'(col)};
		s_axis_tuser = smp_ok;
		do @(negedge clk); while (!s_fire);
		pixels_sent++;
	endtask

	// Holds the sender until every queued result has been delivered.
	task automatic drain;
		s_axis_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input e2q_pkg::reg_idx_t idx, input int value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = 16'(value);
		do @(negedge clk); while (!cfg_fire);
		cfg_valid = 1'b0;
		reg_writes++;
	endtask

	task automatic load_setting(input int fx, input int fy, input int cx, input int cy,
			input int w, input int h);
		drain();
		write_reg(e2q_pkg::REG_FOCAL_X, fx);
		write_reg(e2q_pkg::REG_FOCAL_Y, fy);
		write_reg(e2q_pkg::REG_CENTER_X, cx);
		write_reg(e2q_pkg::REG_CENTER_Y, cy);
		write_reg(e2q_pkg::REG_EQUI_WIDTH, w);
		write_reg(e2q_pkg::REG_EQUI_HEIGHT, h);
	endtask

	// Mostly valid pixels with random content; some outside or not sampled.
	task automatic random_pixels(input int n);
		int col, row, depth;
		bit smp_ok;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 85) begin
				col = $urandom_range(1279);
				row = $urandom_range(719);
				smp_ok = 1'b1;
			end else begin
				col = $urandom_range(2047);
				row = $urandom_range(1023);
				smp_ok = $urandom_range(1);
			end
			case ($urandom_range(3))
				0: depth = $urandom_range(255);
				1: depth = $urandom_range(65535, 60000);
				default: depth = $urandom_range(65535);
			endcase
			send_pixel(col, row, smp_ok, depth, $urandom_range(255),
				$urandom_range(255), $urandom_range(255));
			if (i == n / 2 && $urandom_range(1))
				drain();
		end
	endtask

	task automatic random_setting;
		load_setting($urandom_range(65535, 16), $urandom_range(65535, 16),
			$urandom_range(65535), $urandom_range(65535),
			$urandom_range(4096, 1), $urandom_range(4096, 1));
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed pixels: corners, depth extremes, rejected and extreme fields.
		tx_idle = 0;
		rx_idle = 0;
		send_pixel(0, 0, 1, 1000, 0, 0, 0);
		send_pixel(1279, 719, 1, 1000, 255, 255, 255);
		send_pixel(631, 366, 1, 5000, 1, 2, 3);
		send_pixel(640, 360, 1, 0, 10, 20, 30);
		send_pixel(0, 719, 1, 65535, 128, 64, 32);
		send_pixel(1279, 0, 1, 65535, 85, 170, 85);
		send_pixel(500, 300, 0, 4000, 255, 0, 255);
		send_pixel(1280, 100, 1, 4000, 7, 7, 7);
		send_pixel(100, 720, 1, 4000, 8, 8, 8);
		send_pixel(2047, 1023, 1, 65535, 255, 255, 255);
		send_pixel(2047, 1023, 0, 0, 0, 0, 0);
		send_pixel(640, 0, 1, 1, 9, 9, 9);
		send_pixel(640, 719, 1, 1, 11, 12, 13);

		// Zero focal lengths, zero sizes and sizes beyond the 12-bit index.
		load_setting(0, 0, 0, 0, 0, 0);
		send_pixel(1279, 719, 1, 65535, 1, 1, 1);
		send_pixel(0, 0, 1, 65535, 2, 2, 2);
		send_pixel(640, 360, 1, 30000, 3, 3, 3);
		load_setting(65535, 65535, 65535, 65535, 16'hFFFF, 8191);
		send_pixel(0, 0, 1, 65535, 4, 4, 4);
		send_pixel(1279, 719, 1, 12345, 5, 5, 5);
		load_setting(16, 16, 65535, 0, 4096, 1);
		send_pixel(0, 719, 1, 65535, 6, 6, 6);
		send_pixel(1279, 0, 1, 777, 7, 7, 7);
		send_pixel(640, 360, 1, 100, 8, 8, 8);

		// Three phases, two with sender and receiver stalls, each over several settings.
		for (int ph = 0; ph < 3; ph++) begin
			tx_idle = (ph == 0) ? 31 : (ph == 1) ? 49 : 0;
			rx_idle = (ph == 0) ? 49 : (ph == 1) ? 31 : 0;
			load_setting(10075, 10062, 10095, 5866, 1280, 720);
			random_pixels(300);
			random_setting();
			random_pixels(130);
			load_setting(16, 65535, 0, 65535, 1, 4096);
			random_pixels(130);
		end

		// Wait for the last results, then let the pipeline settle.
		s_axis_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d pixels (%0d written) with %0d register writes,",
			pixels_sent, written, reg_writes);
		$display("covering edge cases and three sender/receiver stall mixes.");
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/e2q_pkg.sv
hdl/e2q_div_cell.sv
hdl/e2q_cordic_cell.sv
hdl/rgbd_pixel_to_equirect_top.sv
verif/e2q_checker.sv
verif/tb_rgbd_pixel_to_equirect_top.sv
